FILE: rtl/boot_mouse_to_ps2_bytes_assert.svh
// Assertion macros for the boot mouse to PS/2 byte converter.
// Used by the checker module; expects clk and rst_n in scope.
`ifndef BOOT_MOUSE_TO_PS2_BYTES_ASSERT_SVH
`define BOOT_MOUSE_TO_PS2_BYTES_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define BM2PS2_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define BM2PS2_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bm2ps2_pkg.sv
// Shared types and constants for the boot mouse to PS/2 byte converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bm2ps2_pkg;

    localparam int ACC_WIDTH_DEF = 16;
    localparam int JOB_BYTES     = 4;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] BTN_MASK = 8'h0f;
    localparam logic [7:0] X_SIGN   = 8'h10;
    localparam logic [7:0] Y_SIGN   = 8'h20;

    // request kinds
    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // configuration register indexes
    localparam int   CFG_IDX_W          = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_PRESENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_OPEN  = 1'b1;

    typedef enum logic [1:0] {
        ST_BYTE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_IDLE   = 2'd2,
        ST_ZERO   = 2'd3
    } status_t;

    // One read's worth of results: bytes in emit order, index of the last one.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [1:0]                last_idx;
        status_t                   status;
    } job_t;

endpackage

`default_nettype wire

FILE: rtl/boot_mouse_to_ps2_bytes.sv
// Boot-protocol mouse report to PS/2 byte stream converter, top level.
// Depends on bm2ps2_pkg, bm2ps2_front, bm2ps2_queue and bm2ps2_back.
//
// Each input transaction is either a USB mouse report or a read request.
// Reports produce no result; they update the button latch and the
// saturating dx/dy/dz accumulators. A read produces one to four
// result transactions: PS/2 bytes in phase order (buttons with sign bits,
// low byte of dx, low byte of dy, and low byte of dz when the read still
// wants more after dy), or a single status result (absent, nothing ready,
// zero count) with last set. The front end settles a whole read in the
// cycle it is accepted and pushes it as one job into a two-entry queue; the
// back end emits one byte per cycle from the queue head through a registered
// output whenever the output is not stalled. Transactions are taken at one per
// cycle, and the input stalls only while the queue is full. Configuration writes
// are always taken (cfg_ready is tied high) and must land only while the
// block is idle.
`timescale 1ns / 1ps
`default_nettype none

module boot_mouse_to_ps2_bytes #(
    parameter int ACC_WIDTH = bm2ps2_pkg::ACC_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bm2ps2_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                             cfg_data,
    // input items
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             req_type,
    input  wire logic                             report_ok,
    input  wire logic [7:0]                       report_buttons,
    input  wire logic signed [7:0]                report_dx,
    input  wire logic signed [7:0]                report_dy,
    input  wire logic signed [7:0]                report_dz,
    input  wire logic [7:0]                       read_count,
    // result items
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [7:0]                            out_byte,
    output logic [1:0]                            out_status,
    output logic                                  last
);
    import bm2ps2_pkg::*;

    logic q_full;
    logic push;
    job_t push_job;
    logic q_valid;
    job_t q_head;
    logic q_pop;

    // Config registers live in the front end; no back-pressure on writes.
    assign cfg_ready = 1'b1;

    // Front: classify each transaction, update state, build the read's job.
    bm2ps2_front #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .report_ok      (report_ok),
        .report_buttons (report_buttons),
        .report_dx      (report_dx),
        .report_dy      (report_dy),
        .report_dz      (report_dz),
        .read_count     (read_count),
        .q_full         (q_full),
        .push           (push),
        .push_job       (push_job)
    );

    // Hold finished read jobs so the front keeps going while output stalls.
    bm2ps2_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    // Back: serialize the head job onto the result channel.
    bm2ps2_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_status (out_status),
        .last       (last)
    );

endmodule

`default_nettype wire

FILE: rtl/bm2ps2_front.sv
// Front end: config registers, report accumulation and read classification.
// Depends on bm2ps2_pkg; pushes one job per read into bm2ps2_queue.
`timescale 1ns / 1ps
`default_nettype none

module bm2ps2_front #(
    parameter int ACC_WIDTH = bm2ps2_pkg::ACC_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr,
    input  wire logic [bm2ps2_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic                                 cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 req_type,
    input  wire logic                                 report_ok,
    input  wire logic [7:0]                           report_buttons,
    input  wire logic signed [7:0]                    report_dx,
    input  wire logic signed [7:0]                    report_dy,
    input  wire logic signed [7:0]                    report_dz,
    input  wire logic [7:0]                           read_count,
    input  wire logic                                 q_full,
    output logic                                      push,
    output bm2ps2_pkg::job_t                          push_job
);
    import bm2ps2_pkg::*;

    localparam int EXT_W = ACC_WIDTH + 1;
    localparam logic signed [EXT_W-1:0] SAT_HI = {2'b00, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_LO = {2'b11, {(ACC_WIDTH-1){1'b0}}};

    logic                        present_reg, present_next;
    logic                        listen_reg, listen_next;
    logic [3:0]                  held_reg, held_next;
    logic signed [ACC_WIDTH-1:0] sum_dx_reg, sum_dx_next;
    logic signed [ACC_WIDTH-1:0] sum_dy_reg, sum_dy_next;
    logic signed [ACC_WIDTH-1:0] sum_dz_reg, sum_dz_next;
    logic                        news_reg, news_next;
    logic [1:0]                  phase_reg, phase_next;

    logic                        accept;
    logic                        take_report;
    logic                        byte_read;
    logic signed [EXT_W-1:0]     dx_ext, dy_ext, dz_ext;
    logic [2:0]                  start, cnt4, avail, n_bytes, end_pos;
    logic [JOB_BYTES-1:0][7:0]   slot;
    logic [JOB_BYTES-1:0]        clr;

    function automatic logic [ACC_WIDTH-1:0] sat(input logic signed [EXT_W-1:0] v);
        if (v > SAT_HI)
            return SAT_HI[ACC_WIDTH-1:0];
        else if (v < SAT_LO)
            return SAT_LO[ACC_WIDTH-1:0];
        else
            return v[ACC_WIDTH-1:0];
    endfunction

    assign in_stall    = q_full;
    assign accept      = in_valid && !in_stall;
    assign take_report = accept && (req_type == REQ_REPORT) && report_ok && listen_reg;
    assign byte_read   = accept && (req_type == REQ_READ) && present_reg && news_reg
                         && (read_count != 8'd0);
    assign push        = accept && (req_type == REQ_READ);

    assign dx_ext = EXT_W'(sum_dx_reg) + EXT_W'(report_dx);
    assign dy_ext = EXT_W'(sum_dy_reg) - EXT_W'(report_dy);
    assign dz_ext = EXT_W'(sum_dz_reg) - EXT_W'(report_dz);

    // Byte slots in phase order: buttons, dx, dy, dz.
    always_comb
    begin
        slot[0] = {4'b0000, held_reg}
                  | (sum_dx_reg[ACC_WIDTH-1] ? X_SIGN : 8'h00)
                  | (sum_dy_reg[ACC_WIDTH-1] ? Y_SIGN : 8'h00);
        slot[1] = sum_dx_reg[7:0];
        slot[2] = sum_dy_reg[7:0];
        slot[3] = sum_dz_reg[7:0];
    end

    // A read emits slots start..start+n-1, n = min(count, 4 - start).
    always_comb
    begin
        start   = (phase_reg == 2'd3) ? 3'd0 : {1'b0, phase_reg};
        cnt4    = (read_count > 8'd4) ? 3'd4 : read_count[2:0];
        avail   = 3'd4 - start;
        n_bytes = (cnt4 < avail) ? cnt4 : avail;
        end_pos = start + n_bytes;
    end

    always_comb
    begin
        logic [2:0] idx;
        idx      = '0;
        push_job = '0;
        priority if (!present_reg)
        begin
            push_job.status = ST_ABSENT;
        end
        else if (!news_reg)
        begin
            push_job.status = ST_IDLE;
        end
        else if (read_count == 8'd0)
        begin
            push_job.status = ST_ZERO;
        end
        else
        begin
            push_job.status   = ST_BYTE;
            push_job.last_idx = 2'(n_bytes - 3'd1);
            for (int k = 0; k < JOB_BYTES; k++)
            begin
                idx = start + 3'(k);
                push_job.bytes[k] = (idx < 3'd4) ? slot[idx[1:0]] : 8'h00;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < JOB_BYTES; j++)
            clr[j] = byte_read && (3'(j) >= start) && (3'(j) < end_pos);
    end

    always_comb
    begin
        present_next = present_reg;
        listen_next  = listen_reg;
        held_next    = held_reg;
        sum_dx_next  = sum_dx_reg;
        sum_dy_next  = sum_dy_reg;
        sum_dz_next  = sum_dz_reg;
        news_next    = news_reg;
        phase_next   = phase_reg;

        if (cfg_wr && (cfg_index == CFG_DEVICE_PRESENT))
            present_next = cfg_data;
        if (cfg_wr && (cfg_index == CFG_LISTENER_OPEN))
            listen_next = cfg_data;

        if (take_report)
        begin
            held_next   = report_buttons[3:0] & BTN_MASK[3:0];
            sum_dx_next = sat(dx_ext);
            sum_dy_next = sat(dy_ext);
            sum_dz_next = sat(dz_ext);
            news_next   = 1'b1;
        end

        if (byte_read)
        begin
            news_next  = 1'b0;
            phase_next = (end_pos >= 3'd3) ? 2'd0 : end_pos[1:0];
            if (clr[0])
                held_next = '0;
            if (clr[1])
                sum_dx_next = '0;
            if (clr[2])
                sum_dy_next = '0;
            if (clr[3])
                sum_dz_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            listen_reg  <= 1'b0;
            held_reg    <= '0;
            sum_dx_reg  <= '0;
            sum_dy_reg  <= '0;
            sum_dz_reg  <= '0;
            news_reg    <= 1'b0;
            phase_reg   <= '0;
        end
        else
        begin
            present_reg <= present_next;
            listen_reg  <= listen_next;
            held_reg    <= held_next;
            sum_dx_reg  <= sum_dx_next;
            sum_dy_reg  <= sum_dy_next;
            sum_dz_reg  <= sum_dz_next;
            news_reg    <= news_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bm2ps2_queue.sv
// Short job queue between the front and back ends.
// Depends on bm2ps2_pkg for job_t and QUEUE_DEPTH.
`timescale 1ns / 1ps
`default_nettype none

module bm2ps2_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  bm2ps2_pkg::job_t push_job,
    output logic             full,
    output logic             q_valid,
    output bm2ps2_pkg::job_t q_head,
    input  wire logic        q_pop
);
    import bm2ps2_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t               slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_head  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bm2ps2_back.sv
// Back end: walks the head job one byte per cycle, when not stalled, into the output register.
// Depends on bm2ps2_pkg; fed by bm2ps2_queue.
`timescale 1ns / 1ps
`default_nettype none

module bm2ps2_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  bm2ps2_pkg::job_t q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic [1:0]       out_status,
    output logic             last
);
    import bm2ps2_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] status_reg, status_next;
    logic       last_reg, last_next;
    logic       load;
    logic       at_end;

    assign load   = !out_valid_reg || !out_stall;
    assign at_end = (idx_reg == q_head.last_idx);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        byte_next      = byte_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        if (load)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                byte_next   = q_head.bytes[idx_reg];
                status_next = q_head.status;
                last_next   = at_end;
                // advance within the job, drop it after its last byte
                q_pop       = at_end;
                idx_next    = at_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign out_status = status_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

FILE: rtl/bm2ps2_checker.sv
// Port-level checker for boot_mouse_to_ps2_bytes, bound to the top level.
// Depends on bm2ps2_pkg and boot_mouse_to_ps2_bytes_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "boot_mouse_to_ps2_bytes_assert.svh"

module bm2ps2_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic [7:0]                       out_byte,
    input wire logic [1:0]                       out_status,
    input wire logic                             last
);
    import bm2ps2_pkg::*;

    // Hold a stalled result transaction.
    `BM2PS2_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_status) && $stable(last), "stalled result changed")

    // Status results stand alone and carry a zero byte.
    `BM2PS2_ASSERT_SAME(a_status_alone, out_valid && (out_status != ST_BYTE), last && (out_byte == 8'h00), "status result not last or byte nonzero")

    // Bytes of one read leave back to back.
    `BM2PS2_ASSERT_NEXT(a_read_burst, out_valid && !out_stall && !last, out_valid && (out_status == ST_BYTE), "gap inside a read's bytes")

endmodule

bind boot_mouse_to_ps2_bytes bm2ps2_checker u_bm2ps2_checker (.*);

`default_nettype wire
